FILE: hw/rtl/cmbstp_pkg.sv
// ----------------------------------------------------------------------------
// cmbstp_pkg
// Shared types and constants for the k-of-n combination stepper.
// ----------------------------------------------------------------------------
package cmbstp_pkg;

    localparam int DEF_MAX_K = 16;
    localparam int DEF_MAX_N = 256;

    localparam int ELEM_W   = 8;
    localparam int N_W      = 9;
    localparam int K_W      = 5;
    localparam int OP_W     = 3;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 9;

    localparam logic [16:0] N_RESET = 17'd16;
    localparam logic [K_W-1:0] K_RESET = 5'd4;

    localparam logic CFG_N_TOTAL  = 1'b0;
    localparam logic CFG_K_CHOSEN = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_FIRST = 3'd0,
        OP_LAST  = 3'd1,
        OP_NEXT  = 3'd2,
        OP_PREV  = 3'd3,
        OP_WRITE = 3'd4,
        OP_READ  = 3'd5,
        OP_CHECK = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NO_MORE = 3'd1,
        ST_INVALID = 3'd2,
        ST_RANGE   = 3'd3,
        ST_BAD_CFG = 3'd4
    } status_t;

endpackage

FILE: hw/rtl/combination_stepper.sv
// ----------------------------------------------------------------------------
// combination_stepper
// Holds a k-of-n combination and steps it in lexicographic order.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with opcode, elem_index, elem_value.
//   Each request gives exactly one response on out_valid/out_stall carrying
//   status and read_value. n_total and k_chosen are written on the cfg port
//   (cfg_write, cfg_index, cfg_data) while no request is in flight.
//   The elements live in a small single-port-read memory; one sequencer walks
//   it with one compare/increment unit, one element per cycle.
//   Write responds straight from idle, read passes through S_LOAD, first/last
//   refill up, check scans up, and next/prev scan down then refill up.
//   in_stall stays high from accept until the response is loaded into the
//   output register; the next request can be accepted in the same cycle that
//   response appears, even while it still waits under out_stall. A stalled
//   response holds the sequencer in its final state until the output
//   register frees.
//   Reset: n_total=16, k_chosen=4, entry i holds i (per-entry valid flags).
// ----------------------------------------------------------------------------
module combination_stepper #(
    parameter int MAX_K = cmbstp_pkg::DEF_MAX_K,
    parameter int MAX_N = cmbstp_pkg::DEF_MAX_N
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [cmbstp_pkg::CFG_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cmbstp_pkg::OP_W-1:0]     opcode,
    input  logic [cmbstp_pkg::IDX_W-1:0]    elem_index,
    input  logic [cmbstp_pkg::ELEM_W-1:0]   elem_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cmbstp_pkg::STATUS_W-1:0] status,
    output logic [cmbstp_pkg::ELEM_W-1:0]   read_value
);
    import cmbstp_pkg::*;

    localparam int IW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW  = $clog2(MAX_K + 1);
    localparam int SW  = N_W + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_SCAN = 5'b00100,
        S_FILL = 5'b01000,
        S_RESP = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    status_t               res_status_reg, res_status_next;
    logic [ELEM_W-1:0]     res_rd_reg, res_rd_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic [ELEM_W-1:0]     val_reg, val_next;
    logic [ELEM_W-1:0]     cur_reg, cur_next;

    logic [N_W-1:0]        n_total_reg;
    logic [K_W-1:0]        k_chosen_reg;

    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [ELEM_W-1:0]     out_rd_reg;

    logic [ELEM_W-1:0]     mem [MAX_K];
    logic [MAX_K-1:0]      vld_reg;
    logic [ELEM_W-1:0]     rdata_reg;
    logic                  mem_we;
    logic [IW-1:0]         mem_wa;
    logic [ELEM_W-1:0]     mem_wd;
    logic [IW-1:0]         rd_addr;

    logic                  in_fire;
    logic                  cfg_bad;
    logic                  resp_load;
    logic [CW-1:0]         kc;
    logic [CW-1:0]         km1;
    logic [CW-1:0]         ptr_p1;
    logic [CW-1:0]         ptr_p2;
    logic [N_W-1:0]        nk;
    logic [SW-1:0]         nk_ptr;
    logic                  fwd_match;
    logic                  bwd_chain;
    logic                  chk_bad;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign read_value = out_rd_reg;

    assign cfg_bad = (n_total_reg == '0) || (N_W'(k_chosen_reg) > n_total_reg) ||
                     (32'(n_total_reg) > 32'(MAX_N)) || (32'(k_chosen_reg) > 32'(MAX_K));
    assign kc      = CW'(k_chosen_reg);
    assign km1     = kc - CW'(1);
    assign ptr_p1  = ptr_reg + CW'(1);
    assign ptr_p2  = ptr_reg + CW'(2);
    assign nk      = n_total_reg - N_W'(k_chosen_reg);
    assign nk_ptr  = SW'(nk) + SW'(ptr_reg);

    // shared compare unit, one element per cycle
    assign fwd_match = (SW'(rdata_reg) == nk_ptr);
    assign bwd_chain = ({1'b0, cur_reg} == ({1'b0, rdata_reg} + 9'd1));
    assign chk_bad   = ({1'b0, rdata_reg} >= n_total_reg) ||
                       ((ptr_reg != '0) && (cur_reg >= rdata_reg));

    assign resp_load = (state_reg == S_RESP) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        ptr_next        = ptr_reg;
        val_next        = val_reg;
        cur_next        = cur_reg;
        mem_we          = 1'b0;
        mem_wa          = ptr_reg[IW-1:0];
        mem_wd          = val_reg;
        rd_addr         = ptr_reg[IW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next         = op_t'(opcode);
                    res_status_next = ST_OK;
                    res_rd_next     = '0;
                    state_next      = S_RESP;
                    if (cfg_bad)
                    begin
                        res_status_next = ST_BAD_CFG;
                    end
                    else
                    begin
                        case (op_t'(opcode))
                            OP_FIRST, OP_LAST:
                            begin
                                if (kc != '0)
                                begin
                                    ptr_next   = '0;
                                    val_next   = (op_t'(opcode) == OP_FIRST) ? '0 : nk[ELEM_W-1:0];
                                    state_next = S_FILL;
                                end
                            end
                            OP_NEXT, OP_PREV:
                            begin
                                if (kc == '0)
                                begin
                                    res_status_next = ST_NO_MORE;
                                end
                                else
                                begin
                                    ptr_next   = km1;
                                    rd_addr    = km1[IW-1:0];
                                    state_next = (op_t'(opcode) == OP_NEXT) ? S_SCAN : S_LOAD;
                                end
                            end
                            OP_WRITE:
                            begin
                                if (K_W'(elem_index) >= k_chosen_reg)
                                begin
                                    res_status_next = ST_RANGE;
                                end
                                else
                                begin
                                    mem_we = 1'b1;
                                    mem_wa = IW'(elem_index);
                                    mem_wd = elem_value;
                                end
                            end
                            OP_READ:
                            begin
                                if (K_W'(elem_index) >= k_chosen_reg)
                                begin
                                    res_status_next = ST_RANGE;
                                end
                                else
                                begin
                                    rd_addr    = IW'(elem_index);
                                    state_next = S_LOAD;
                                end
                            end
                            OP_CHECK:
                            begin
                                if (kc != '0)
                                begin
                                    ptr_next   = '0;
                                    rd_addr    = '0;
                                    state_next = S_SCAN;
                                end
                            end
                            default:
                            begin
                                res_status_next = ST_INVALID;
                            end
                        endcase
                    end
                end
            end

            S_LOAD:
            begin
                if (op_reg == OP_READ)
                begin
                    res_rd_next = rdata_reg;
                    state_next  = S_RESP;
                end
                else if (ptr_reg == '0)
                begin
                    // prev with k of one: only the first entry can move
                    state_next = S_RESP;
                    if (rdata_reg == '0)
                    begin
                        res_status_next = ST_NO_MORE;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        mem_wa = '0;
                        mem_wd = rdata_reg - 8'd1;
                    end
                end
                else
                begin
                    cur_next   = rdata_reg;
                    ptr_next   = ptr_reg - CW'(1);
                    rd_addr    = IW'(ptr_reg - CW'(1));
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                case (op_reg)
                    OP_NEXT:
                    begin
                        if (!fwd_match)
                        begin
                            mem_we   = 1'b1;
                            mem_wa   = ptr_reg[IW-1:0];
                            mem_wd   = rdata_reg + 8'd1;
                            ptr_next = ptr_p1;
                            val_next = rdata_reg + 8'd2;
                            state_next = (ptr_p1 < kc) ? S_FILL : S_RESP;
                        end
                        else if (ptr_reg == '0)
                        begin
                            res_status_next = ST_NO_MORE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            ptr_next = ptr_reg - CW'(1);
                            rd_addr  = IW'(ptr_reg - CW'(1));
                        end
                    end
                    OP_PREV:
                    begin
                        // rdata is entry ptr, cur is entry ptr+1
                        if (!bwd_chain)
                        begin
                            mem_we   = 1'b1;
                            mem_wa   = ptr_p1[IW-1:0];
                            mem_wd   = cur_reg - 8'd1;
                            ptr_next = ptr_p2;
                            val_next = ELEM_W'(nk_ptr + SW'(2));
                            state_next = (ptr_p2 < kc) ? S_FILL : S_RESP;
                        end
                        else if (ptr_reg == '0)
                        begin
                            if (rdata_reg == '0)
                            begin
                                res_status_next = ST_NO_MORE;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                mem_wa   = '0;
                                mem_wd   = rdata_reg - 8'd1;
                                ptr_next = CW'(1);
                                val_next = ELEM_W'(nk_ptr + SW'(1));
                                state_next = S_FILL;
                            end
                        end
                        else
                        begin
                            cur_next = rdata_reg;
                            ptr_next = ptr_reg - CW'(1);
                            rd_addr  = IW'(ptr_reg - CW'(1));
                        end
                    end
                    default:
                    begin
                        // validity check, ascending; cur holds the previous entry
                        if (chk_bad)
                        begin
                            res_status_next = ST_INVALID;
                            state_next      = S_RESP;
                        end
                        else if (ptr_reg == km1)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cur_next = rdata_reg;
                            ptr_next = ptr_p1;
                            rd_addr  = ptr_p1[IW-1:0];
                        end
                    end
                endcase
            end

            S_FILL:
            begin
                mem_we   = 1'b1;
                mem_wa   = ptr_reg[IW-1:0];
                mem_wd   = val_reg;
                ptr_next = ptr_p1;
                val_next = val_reg + 8'd1;
                if (ptr_reg == km1)
                begin
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (resp_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            n_total_reg    <= N_RESET[N_W-1:0];
            k_chosen_reg   <= K_RESET;
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_N_TOTAL:  n_total_reg  <= cfg_data;
                    CFG_K_CHOSEN: k_chosen_reg <= cfg_data[K_W-1:0];
                    default:      ;
                endcase
            end
            if (mem_we)
            begin
                vld_reg[mem_wa] <= 1'b1;
            end
            if (resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        ptr_reg        <= ptr_next;
        val_reg        <= val_next;
        cur_reg        <= cur_next;
        if (resp_load)
        begin
            out_status_reg <= res_status_reg;
            out_rd_reg     <= res_rd_reg;
        end
    end

    // element store; entries never written read as their own index
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= vld_reg[rd_addr] ? mem[rd_addr] : ELEM_W'(rd_addr);
    end

    a_bad_cfg_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cfg_bad) |=> (state_reg == S_RESP) && (res_status_reg == ST_BAD_CFG))
        else $error("bad configuration did not short-circuit to response");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (ptr_reg < kc))
        else $error("fill pointer past k");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (ptr_reg < kc))
        else $error("scan pointer past k");

    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_status_reg == ST_OK) || (out_rd_reg == '0)))
        else $error("nonzero read value on failed request");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg_bad && (op_t'(opcode) == OP_NEXT) && (kc != '0))
        |=> in_stall && (state_reg == S_SCAN))
        else $error("step request did not start a scan");

endmodule
